>>> design/mfpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_pkg
// Types and constants shared by the motor fader position control block.
// ----------------------------------------------------------------------------
package mfpc_pkg;

    // register map, byte address = 4 * index
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_DRIVE_LEVEL     = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_REPORT_INTERVAL = 3'd4;

    localparam logic [7:0]  DRIVE_LEVEL_RST     = 8'd255;
    localparam logic [15:0] REPORT_INTERVAL_RST = 16'd100;

    // pos = raw*255/660 = raw*51/132; divide by 132 as multiply by
    // ceil(2^23/132), exact for raw*51 below 67650
    localparam logic [5:0]  SCALE_MUL   = 6'd51;
    localparam logic [15:0] RECIP_132   = 16'd63551;
    localparam int unsigned RECIP_SHIFT = 23;

    localparam logic signed [9:0] NEAR_BAND   = 10'sd4;
    localparam logic signed [9:0] UP_MIN_DIST = 10'sd23;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_SET    = 1'b1;

    typedef enum logic [2:0] {
        DIR_STOP = 3'b001,
        DIR_DOWN = 3'b010,
        DIR_UP   = 3'b100
    } t_dir;

    typedef struct packed {
        logic [7:0]  target;
        logic        reached;
        t_dir        dir;
        logic [31:0] last_time;
        logic [8:0]  last_pos;
    } t_state;

    typedef struct packed {
        logic               action;
        logic [9:0]         wiper_raw;
        logic signed [15:0] target_request;
        logic [31:0]        now_ms;
    } t_item;

    typedef struct packed {
        logic [7:0] motor_a_level;
        logic [7:0] motor_b_level;
        logic       at_target;
        logic       report_valid;
        logic [8:0] report_value;
    } t_result;

    typedef struct packed {
        logic [7:0]  drive_level;
        logic [15:0] report_interval_ms;
    } t_cfg;

endpackage

>>> design/mfpc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_in_if
// Input channel: one command or wiper sample item per handshake.
// ----------------------------------------------------------------------------
interface mfpc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [9:0]         wiper_raw;
    logic signed [15:0] target_request;
    logic [31:0]        now_ms;

    modport source (output valid, action, wiper_raw, target_request, now_ms,
                    input ready);
    modport sink   (input valid, action, wiper_raw, target_request, now_ms,
                    output ready);
endinterface

>>> design/mfpc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_out_if
// Result channel: motor leg duties, reached flag and live position report.
// ----------------------------------------------------------------------------
interface mfpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] motor_a_level;
    logic [7:0] motor_b_level;
    logic       at_target;
    logic       report_valid;
    logic [8:0] report_value;

    modport source (output valid, motor_a_level, motor_b_level, at_target,
                    report_valid, report_value, input ready);
    modport sink   (input valid, motor_a_level, motor_b_level, at_target,
                    report_valid, report_value, output ready);
endinterface

>>> design/motor_fader_position_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_fader_position_control
// Bang-bang position control of a motorized fader with live position reports.
// ----------------------------------------------------------------------------
// Pipeline: item accept into the input register, then decision logic into
// the result register; an item waits while the result register is held.
// Throughput: one item per cycle while results are taken; the decision and
// state update are combinational in the core between the two registers.
// Reset: synchronous, active low; pipeline emptied, state and registers set
// to their defaults (target 0, reached, motor stopped).
// ----------------------------------------------------------------------------
module motor_fader_position_control
    import mfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfpc_in_if.sink           i_item,
    mfpc_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in;
    logic    r_in_v;
    t_result r_res;
    t_result n_res;
    logic    r_res_v;
    logic    advance;
    logic    cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_level        <= DRIVE_LEVEL_RST;
            r_cfg.report_interval_ms <= REPORT_INTERVAL_RST;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_DRIVE_LEVEL:     r_cfg.drive_level        <= pwdata[7:0];
                ADDR_REPORT_INTERVAL: r_cfg.report_interval_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_DRIVE_LEVEL:     prdata = {24'd0, r_cfg.drive_level};
            ADDR_REPORT_INTERVAL: prdata = {16'd0, r_cfg.report_interval_ms};
            default:              prdata = 32'd0;
        endcase
    end

    // pipeline control: the input stage moves on when the result register frees
    assign advance      = r_in_v && (!r_res_v || o_result.ready);
    assign i_item.ready = !r_in_v || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_item.ready) begin
            r_in_v <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action         <= i_item.action;
            r_in.wiper_raw      <= i_item.wiper_raw;
            r_in.target_request <= i_item.target_request;
            r_in.now_ms         <= i_item.now_ms;
        end
    end

    mfpc_core u_core (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.target    <= 8'd0;
            r_state.reached   <= 1'b1;
            r_state.dir       <= DIR_STOP;
            r_state.last_time <= 32'd0;
            r_state.last_pos  <= 9'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (advance) begin
            r_res_v <= 1'b1;
        end else if (o_result.ready) begin
            r_res_v <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid         = r_res_v;
    assign o_result.motor_a_level = r_res.motor_a_level;
    assign o_result.motor_b_level = r_res.motor_b_level;
    assign o_result.at_target     = r_res.at_target;
    assign o_result.report_valid  = r_res.report_valid;
    assign o_result.report_value  = r_res.report_value;

endmodule

>>> design/mfpc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_core
// Per-item decision: wiper scaling, drive choice, reached flag and report.
// ----------------------------------------------------------------------------
module mfpc_core
    import mfpc_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [15:0]        scaled;
    logic [31:0]        prod;
    logic [8:0]         pos;
    logic [7:0]         clamped;
    logic signed [9:0]  tgt_diff;
    logic signed [9:0]  rep_diff;
    logic [31:0]        elapsed;
    logic               interval_ok;
    logic               moved;
    t_state             n_state;
    logic               rep_valid;
    logic [8:0]         rep_value;

    assign scaled   = 16'(i_item.wiper_raw) * 16'(SCALE_MUL);
    assign prod     = 32'(scaled) * 32'(RECIP_132);
    assign pos      = prod[RECIP_SHIFT +: 9];

    assign tgt_diff = $signed({1'b0, pos}) - $signed({2'b00, i_state.target});
    assign rep_diff = $signed({1'b0, pos}) - $signed({1'b0, i_state.last_pos});
    assign elapsed  = i_item.now_ms - i_state.last_time;

    assign interval_ok = elapsed >= {16'd0, i_cfg.report_interval_ms};
    assign moved       = (rep_diff > NEAR_BAND) || (rep_diff < -NEAR_BAND);

    always_comb begin
        if (i_item.target_request < 16'sd0) begin
            clamped = 8'd0;
        end else if (i_item.target_request > 16'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = i_item.target_request[7:0];
        end
    end

    always_comb begin
        n_state   = i_state;
        rep_valid = 1'b0;
        rep_value = 9'd0;
        if (i_item.action == ACT_SET) begin
            n_state.target  = clamped;
            n_state.reached = 1'b0;
        end else if (i_state.reached) begin
            if (interval_ok && moved) begin
                rep_valid         = 1'b1;
                rep_value         = pos;
                n_state.last_time = i_item.now_ms;
                n_state.last_pos  = pos;
            end
            n_state.dir = DIR_STOP;
        end else if ((tgt_diff <= NEAR_BAND) && (tgt_diff >= -NEAR_BAND)) begin
            n_state.reached = 1'b1;
            n_state.dir     = DIR_STOP;
        end else if (tgt_diff > 10'sd0) begin
            n_state.dir = DIR_DOWN;
        end else if (tgt_diff <= -UP_MIN_DIST) begin
            n_state.dir = DIR_UP;
        end
        // otherwise keep the previous drive
    end

    assign o_state                = n_state;
    assign o_result.motor_a_level = (n_state.dir == DIR_DOWN) ? i_cfg.drive_level : 8'd0;
    assign o_result.motor_b_level = (n_state.dir == DIR_UP) ? i_cfg.drive_level : 8'd0;
    assign o_result.at_target     = n_state.reached;
    assign o_result.report_valid  = rep_valid;
    assign o_result.report_value  = rep_value;

endmodule

>>> tb/mfpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_checker
// Watches the item and result channels and the register port of the motor
// fader position control block. It keeps its own model of the fader state
// and the register settings. For every accepted item it queues the expected
// result, and it compares each accepted result, field by field, with the
// oldest one queued.
// ----------------------------------------------------------------------------
module mfpc_checker
    import mfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfpc_in_if                i_item,
    mfpc_out_if               i_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_report_count
);

    // keep the log readable when the block is badly broken
    localparam int MAX_PRINTED = 100;

    t_state  fader_st;
    t_cfg    reg_cfg;
    t_result expected_q[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_report_count = 0;
    end

    function automatic int dist_between(input int a, input int b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // advance the fader state by one item and return the result it gives
    function automatic t_result advance_fader(input t_item it);
        t_result     r;
        int          req;
        int          pos;
        int          tgt;
        logic [31:0] since;
        r = '0;
        if (it.action == ACT_SET) begin
            req = int'(it.target_request);
            if (req < 0) req = 0;
            if (req > 255) req = 255;
            fader_st.target  = req[7:0];
            fader_st.reached = 1'b0;
        end else begin
            pos   = (int'(it.wiper_raw) * 255) / 660;
            tgt   = int'(fader_st.target);
            since = it.now_ms - fader_st.last_time;
            if (fader_st.reached) begin
                if (since >= 32'(reg_cfg.report_interval_ms) &&
                    dist_between(pos, int'(fader_st.last_pos)) > int'(NEAR_BAND)) begin
                    r.report_valid     = 1'b1;
                    r.report_value     = pos[8:0];
                    fader_st.last_time = it.now_ms;
                    fader_st.last_pos  = pos[8:0];
                end
                fader_st.dir = DIR_STOP;
            end else if (dist_between(pos, tgt) <= int'(NEAR_BAND)) begin
                fader_st.reached = 1'b1;
                fader_st.dir     = DIR_STOP;
            end else if (pos > tgt) begin
                fader_st.dir = DIR_DOWN;
            end else if (tgt - pos >= int'(UP_MIN_DIST)) begin
                fader_st.dir = DIR_UP;
            end
            // otherwise hold the previous drive
        end
        r.motor_a_level = (fader_st.dir == DIR_DOWN) ? reg_cfg.drive_level : 8'd0;
        r.motor_b_level = (fader_st.dir == DIR_UP) ? reg_cfg.drive_level : 8'd0;
        r.at_target     = fader_st.reached;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (o_fail_count < MAX_PRINTED)
                $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   seen_item;
        t_result want;
        if (!i_rst_n) begin
            fader_st.target    = '0;
            fader_st.reached   = 1'b1;
            fader_st.dir       = DIR_STOP;
            fader_st.last_time = '0;
            fader_st.last_pos  = '0;
            reg_cfg.drive_level        = DRIVE_LEVEL_RST;
            reg_cfg.report_interval_ms = REPORT_INTERVAL_RST;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_DRIVE_LEVEL:     reg_cfg.drive_level        = pwdata[7:0];
                    ADDR_REPORT_INTERVAL: reg_cfg.report_interval_ms = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    if (o_fail_count < MAX_PRINTED)
                        $error("result arrived with no item outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("motor_a_level", 32'(want.motor_a_level),
                                32'(i_result.motor_a_level));
                    check_field("motor_b_level", 32'(want.motor_b_level),
                                32'(i_result.motor_b_level));
                    check_field("at_target", 32'(want.at_target),
                                32'(i_result.at_target));
                    check_field("report_valid", 32'(want.report_valid),
                                32'(i_result.report_valid));
                    check_field("report_value", 32'(want.report_value),
                                32'(i_result.report_value));
                end
            end
            if (i_item.valid && i_item.ready) begin
                seen_item.action         = i_item.action;
                seen_item.wiper_raw      = i_item.wiper_raw;
                seen_item.target_request = i_item.target_request;
                seen_item.now_ms         = i_item.now_ms;
                want = advance_fader(seen_item);
                if (want.report_valid) o_report_count++;
                expected_q.push_back(want);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

>>> tb/tb_motor_fader_position_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_fader_position_control
// Drives the motor fader position control block with a directed opening and
// then random phases under several register settings: target moves, fader
// travel towards the target, settling with live reports and random noise
// items, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_motor_fader_position_control;
    import mfpc_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int ITEMS_PER_PHASE = 315;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 1000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;
    int report_count;
    int cycle_count = 0;
    int n_items     = 0;
    int n_sets      = 0;
    int n_settings  = 0;

    bit          src_idle  = 1'b1;
    bit          sink_idle = 1'b1;
    bit          hold_req  = 1'b0;
    logic [31:0] clock_ms;

    mfpc_in_if  item_ch ();
    mfpc_out_if result_ch ();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    motor_fader_position_control dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mfpc_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item_ch),
        .i_result       (result_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_report_count (report_count)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(16, 48);
    endfunction

    function automatic int clamp_raw(input int raw);
        if (raw < 0) return 0;
        if (raw > 1023) return 1023;
        return raw;
    endfunction

    // result side: random ready with gaps, or a long hold when asked
    initial begin
        int run_len;
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                run_len = $urandom_range(1, 24);
                result_ch.ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                gap = sink_idle ? pick_gap() : 0;
                if (gap > 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // called at a rising edge; leaves valid high on return
    task automatic send_item(input t_item it);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.action         <= it.action;
        item_ch.wiper_raw      <= it.wiper_raw;
        item_ch.target_request <= it.target_request;
        item_ch.now_ms         <= it.now_ms;
        do @(posedge i_clk); while (!item_ch.ready);
        n_items++;
        if (it.action == ACT_SET) n_sets++;
    endtask

    task automatic send_sample(input int raw, input logic [31:0] now);
        t_item it;
        it.action         = ACT_SAMPLE;
        it.wiper_raw      = raw[9:0];
        it.target_request = 16'($urandom);
        it.now_ms         = now;
        send_item(it);
    endtask

    task automatic send_set(input logic signed [15:0] req);
        t_item it;
        it.action         = ACT_SET;
        it.wiper_raw      = 10'($urandom);
        it.target_request = req;
        it.now_ms         = $urandom;
        send_item(it);
    endtask

    // drop valid and wait for every outstanding result
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_directed();
        // report mode straight out of reset: no move, full scale, interval
        // not yet passed, small move
        send_sample(0, 32'd0);
        send_sample(1023, 32'd100);
        send_sample(1023, 32'd150);
        send_sample(660, 32'd300);
        send_sample(665, 32'd450);
        // target clamping at both ends
        send_set(-16'sd32768);
        send_set(16'sd32767);
        send_set(16'sd300);
        send_set(-16'sd1);
        send_set(16'sd128);
        // up, keep, down, keep down, reached
        send_sample(0, 32'd500);
        send_sample(300, 32'd520);
        send_sample(400, 32'd540);
        send_sample(320, 32'd560);
        send_sample(331, 32'd580);
        // distance of 22 holds, 23 drives up, 5 holds, 4 is reached
        send_set(16'sd100);
        send_sample(1023, 32'd600);
        send_sample(0, 32'd620);
        send_sample(202, 32'd640);
        send_sample(200, 32'd660);
        send_sample(246, 32'd680);
        send_sample(249, 32'd700);
        // reports across the wrap of the millisecond time
        send_sample(0, 32'hFFFF_FFF0);
        send_sample(1023, 32'h0000_0040);
        send_sample(1023, 32'h0000_0060);
    endtask

    task automatic run_phase(input int n_wanted);
        int                 sent;
        int                 tgt;
        int                 goal_raw;
        int                 fader_raw;
        logic signed [15:0] req;
        t_item              it;
        sent      = 0;
        fader_raw = $urandom_range(0, 1023);
        while (sent < n_wanted) begin
            if ($urandom_range(0, 99) < 80) begin
                // move the target, travel towards it, then settle around it
                if ($urandom_range(0, 99) < 85) req = 16'($urandom_range(0, 255));
                else req = 16'($urandom);
                tgt = (req < 0) ? 0 : ((req > 255) ? 255 : int'(req));
                if ($urandom_range(0, 99) < 5)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
                send_set(req);
                sent++;
                goal_raw = (tgt * 660) / 255 + $urandom_range(0, 2);
                repeat ($urandom_range(4, 24)) begin
                    if (fader_raw < goal_raw) fader_raw += $urandom_range(1, 80);
                    else fader_raw -= $urandom_range(1, 80);
                    fader_raw = clamp_raw(fader_raw + int'($urandom_range(0, 6)) - 3);
                    clock_ms += $urandom_range(0, 40);
                    send_sample(fader_raw, clock_ms);
                    sent++;
                end
                repeat ($urandom_range(2, 12)) begin
                    fader_raw = clamp_raw(fader_raw + int'($urandom_range(0, 40)) - 20);
                    if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 70000);
                    else clock_ms += $urandom_range(0, 150);
                    send_sample(fader_raw, clock_ms);
                    sent++;
                end
            end else begin
                it.action         = 1'($urandom);
                it.wiper_raw      = 10'($urandom);
                it.target_request = 16'($urandom);
                it.now_ms         = $urandom;
                send_item(it);
                sent++;
            end
        end
    endtask

    task automatic run_setting(input logic [7:0] level, input logic [15:0] interval,
                               input bit idle_src, input bit idle_sink, input bit stall);
        apb_write(ADDR_DRIVE_LEVEL, 32'(level));
        apb_write(ADDR_REPORT_INTERVAL, 32'(interval));
        n_settings++;
        src_idle  = idle_src;
        sink_idle = idle_sink;
        if (stall) hold_req = 1'b1;
        run_phase(ITEMS_PER_PHASE);
        quiesce();
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.action         <= ACT_SAMPLE;
        item_ch.wiper_raw      <= '0;
        item_ch.target_request <= '0;
        item_ch.now_ms         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        quiesce();

        clock_ms = 32'd1000;
        run_setting(8'd200, 16'd100, 1'b1, 1'b1, 1'b0);
        run_setting(8'd0, 16'd0, 1'b1, 1'b1, 1'b0);
        run_setting(8'd255, 16'd65535, 1'b1, 1'b0, 1'b1);
        run_setting(8'd1, 16'd1, 1'b0, 1'b0, 1'b0);
        run_setting(8'($urandom), 16'($urandom_range(0, 400)), 1'b1, 1'b1, 1'b0);
        run_setting(8'd255, 16'd100, 1'b0, 1'b1, 1'b0);

        $display("Covered %0d items (%0d target moves) under %0d register settings",
                 n_items, n_sets, n_settings);
        $display("Live position reports checked: %0d", report_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
